>>> rtl/core/wcr_pkg.sv
// wcr_pkg: shared constants, types and tables for the wireframe cube rotator.
// Depends on nothing; used by every module in rtl/core.
`default_nettype none
package wcr_pkg;

   localparam int CordicSteps = 16;
   localparam int AtanLen     = 24;
   localparam int NumVert     = 8;
   localparam int NumEdge     = 12;
   localparam int StepW       = 5;
   localparam int VertW       = 3;
   localparam int EdgeW       = 4;
   localparam int CoordW      = 16;
   localparam int CordW       = 34;  // CORDIC x/y/z working width, Q30 plus headroom

   localparam logic signed [CordW-1:0] Q30Pi     = 34'sd3373259426;
   localparam logic signed [CordW-1:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [CordW-1:0] Q30Gain   = 34'sd652032874;
   localparam logic signed [CoordW-1:0] CubeHalf = 16'sd3840;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [CordW-1:0]  cord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   // Trig result handed from the CORDIC unit to the sequencer.
   typedef struct packed {
      logic     done;
      cord_type sin_v;
      cord_type cos_v;
   } trig_type;

   function automatic cord_type atan_q30(input logic [StepW-1:0] i);
      case (i)
         5'd0:  atan_q30 = 34'sh03243F6A8;
         5'd1:  atan_q30 = 34'sh01DAC6705;
         5'd2:  atan_q30 = 34'sh00FADBAFC;
         5'd3:  atan_q30 = 34'sh007F56EA6;
         5'd4:  atan_q30 = 34'sh003FEAB76;
         5'd5:  atan_q30 = 34'sh001FFD55B;
         5'd6:  atan_q30 = 34'sh000FFFAAA;
         5'd7:  atan_q30 = 34'sh0007FFF55;
         5'd8:  atan_q30 = 34'sh0003FFFEA;
         5'd9:  atan_q30 = 34'sh0001FFFFD;
         5'd10: atan_q30 = 34'sh0000FFFFF;
         5'd11: atan_q30 = 34'sh00007FFFF;
         5'd12: atan_q30 = 34'sh00003FFFF;
         5'd13: atan_q30 = 34'sh00001FFFF;
         5'd14: atan_q30 = 34'sh00000FFFF;
         5'd15: atan_q30 = 34'sh000007FFF;
         5'd16: atan_q30 = 34'sh000003FFF;
         5'd17: atan_q30 = 34'sh000001FFF;
         5'd18: atan_q30 = 34'sh000000FFF;
         5'd19: atan_q30 = 34'sh0000007FF;
         5'd20: atan_q30 = 34'sh0000003FF;
         5'd21: atan_q30 = 34'sh0000001FF;
         5'd22: atan_q30 = 34'sh0000000FF;
         5'd23: atan_q30 = 34'sh00000007F;
         default: atan_q30 = '0;
      endcase
   endfunction

   // Edge endpoint vertex indexes: start and end.
   function automatic logic [VertW-1:0] edge_vtx(input logic [EdgeW-1:0] e,
                                                  input logic sel_end);
      logic [2*VertW-1:0] pr;
      case (e)
         4'd0:  pr = {3'd0, 3'd1};
         4'd1:  pr = {3'd1, 3'd2};
         4'd2:  pr = {3'd2, 3'd3};
         4'd3:  pr = {3'd3, 3'd0};
         4'd4:  pr = {3'd4, 3'd5};
         4'd5:  pr = {3'd5, 3'd6};
         4'd6:  pr = {3'd6, 3'd7};
         4'd7:  pr = {3'd7, 3'd4};
         4'd8:  pr = {3'd7, 3'd3};
         4'd9:  pr = {3'd6, 3'd2};
         4'd10: pr = {3'd5, 3'd1};
         4'd11: pr = {3'd4, 3'd0};
         default: pr = '0;
      endcase
      edge_vtx = sel_end ? pr[VertW-1:0] : pr[2*VertW-1:VertW];
   endfunction

   // Reset corner: index pattern gives sign per axis (x from bit1, y from bit0 xor bit1, z from bit2).
   function automatic vertex_type corner(input logic [VertW-1:0] v);
      vertex_type r;
      logic sx;
      logic sy;
      logic sz;
      sx = (v == 3'd2) || (v == 3'd3) || (v == 3'd6) || (v == 3'd7);
      sy = (v == 3'd1) || (v == 3'd2) || (v == 3'd5) || (v == 3'd6);
      sz = v[2];
      r.x = sx ? CubeHalf : -CubeHalf;
      r.y = sy ? CubeHalf : -CubeHalf;
      r.z = sz ? CubeHalf : -CubeHalf;
      corner = r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/wcr_cordic.sv
// wcr_cordic: iterative CORDIC, one micro-rotation per cycle, with quadrant folding.
// Depends on wcr_pkg.
`default_nettype none
module wcr_cordic (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [14:0]    angle,
   output wcr_pkg::trig_type          trig
);
   wcr_pkg::cord_type x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [wcr_pkg::StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, flip_ff, flip_in, done_ff, done_in;
   wcr_pkg::cord_type z0, dx, dy;

   localparam int LastStep = ((wcr_pkg::CordicSteps < wcr_pkg::AtanLen) ?
                              wcr_pkg::CordicSteps : wcr_pkg::AtanLen) - 1;

   // Fold the widened angle into -pi/2..pi/2 on start; while busy, one micro-rotation per step
   always_comb begin
      z0 = wcr_pkg::cord_type'({{(wcr_pkg::CordW-15){angle[14]}}, angle}) <<< 18;
      dx = x_ff >>> step_ff;
      dy = y_ff >>> step_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; busy_in = busy_ff; flip_in = flip_ff; done_in = 1'b0;
      if (start) begin
         x_in = wcr_pkg::Q30Gain;
         y_in = '0;
         step_in = '0;
         busy_in = 1'b1;
         flip_in = 1'b0;
         z_in = z0;
         if (z0 > wcr_pkg::Q30HalfPi) begin
            z_in = z0 - wcr_pkg::Q30Pi; flip_in = 1'b1;
         end else if (z0 < -wcr_pkg::Q30HalfPi) begin
            z_in = z0 + wcr_pkg::Q30Pi; flip_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[wcr_pkg::CordW-1]) begin
            x_in = x_ff - dy; y_in = y_ff + dx;
            z_in = z_ff - wcr_pkg::atan_q30(step_ff);
         end else begin
            x_in = x_ff + dy; y_in = y_ff - dx;
            z_in = z_ff + wcr_pkg::atan_q30(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep[wcr_pkg::StepW-1:0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      step_ff <= step_in; flip_ff <= flip_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign trig.done  = done_ff;
   assign trig.cos_v = flip_ff ? -x_ff : x_ff;
   assign trig.sin_v = flip_ff ? -y_ff : y_ff;
endmodule
`default_nettype wire

>>> rtl/core/wcr_rotate.sv
// wcr_rotate: rotation datapath a' = c*a + sin_a*b, b' = sin_b*a + c*b.
// Products registered, then rounded, shifted and saturated. Depends on wcr_pkg.
`default_nettype none
module wcr_rotate (
   input  wire logic                clock,
   input  wire wcr_pkg::cord_type   cos_v,
   input  wire wcr_pkg::cord_type   sin_a,   // multiplies b for a'
   input  wire wcr_pkg::cord_type   sin_b,   // multiplies a for b'
   input  wire wcr_pkg::coord_type  a,
   input  wire wcr_pkg::coord_type  b,
   output wcr_pkg::coord_type       a_out,
   output wcr_pkg::coord_type       b_out
);
   localparam int PW = wcr_pkg::CordW + wcr_pkg::CoordW;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;

   function automatic wcr_pkg::coord_type comb2(input logic signed [PW-1:0] p,
                                                input logic signed [PW-1:0] q);
      logic signed [PW:0] s;
      logic signed [PW-30:0] r;
      s = {p[PW-1], p} + {q[PW-1], q} + (PW+1)'(64'sd536870912);
      r = s[PW:30];
      if (r > 32767) comb2 = 16'sh7FFF;
      else if (r < -32768) comb2 = 16'sh8000;
      else comb2 = r[15:0];
   endfunction

   // Products
   always_ff @(posedge clock) begin
      p0_ff <= PW'(cos_v) * PW'(a);
      p1_ff <= PW'(sin_a) * PW'(b);
      p2_ff <= PW'(sin_b) * PW'(a);
      p3_ff <= PW'(cos_v) * PW'(b);
   end

   // Round, shift, saturate
   assign a_out = comb2(p0_ff, p1_ff);
   assign b_out = comb2(p2_ff, p3_ff);
endmodule
`default_nettype wire

>>> rtl/core/wcr_vstore.sv
// wcr_vstore: vertex memory, 8 x 48 bits, one write and one registered read port.
// Depends on wcr_pkg.
`default_nettype none
module wcr_vstore (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [wcr_pkg::VertW-1:0]      wr_addr,
   input  wire wcr_pkg::vertex_type            wr_data,
   input  wire logic [wcr_pkg::VertW-1:0]      rd_addr,
   output wcr_pkg::vertex_type                 rd_data
);
   wcr_pkg::vertex_type mem [wcr_pkg::NumVert];
   wcr_pkg::vertex_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule
`default_nettype wire

>>> rtl/core/wireframe_cube_rotator.sv
// Wireframe cube rotator: vertex memory read-modify-write sequencer and edge emitter.
// Depends on wcr_pkg, wcr_cordic, wcr_rotate, wcr_vstore.
//
// Holds the eight corners of a cube (Q7.8) in a small vertex memory. Each request
// carries yaw and pitch in radians times 4096. A nonzero yaw rotates every vertex
// about the vertical axis, then a nonzero pitch about the horizontal axis; the
// cube's edges then leave as screen endpoints, the last one flagged. After reset
// a clearing pass writes the cube corners before the first request. Per request:
// the idle state accepts it; each nonzero angle costs a sine/cosine computation
// (one start state, 16 CORDIC steps, one handoff) plus a vertex rotation pass
// (one memory read-modify-write per vertex, pipelined through the registered
// multiplier); the edges take two memory reads each, and each edge is held
// until the consumer is ready.
`default_nettype none
module wireframe_cube_rotator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [14:0] req_yaw_angle,
   input  wire logic signed [14:0] req_pitch_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [6:0]              rsp_x_start,
   output logic [5:0]              rsp_y_start,
   output logic [6:0]              rsp_x_end,
   output logic [5:0]              rsp_y_end,
   output logic                    rsp_last_segment
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_TRIG_START, S_TRIG_WAIT, S_ROT, S_EDGE_A, S_EDGE_B,
      S_EDGE_C, S_EDGE_OUT
   } state_type;

   state_type state_ff;
   logic signed [14:0] pitch_ff;
   logic phase_ff;                       // 0 = yaw pass, 1 = pitch pass
   logic [wcr_pkg::VertW:0] rcnt_ff;     // vertices read in rotation pass
   logic [wcr_pkg::VertW:0] wcnt_ff;     // vertices written back
   logic [wcr_pkg::EdgeW-1:0] edge_ff;
   logic [wcr_pkg::VertW-1:0] clr_ff;
   logic signed [14:0] ang_ff;
   wcr_pkg::cord_type s_ff, c_ff;
   // rotation pipeline valid/address: read -> mul -> write
   logic v1_ff, v2_ff;
   logic [wcr_pkg::VertW-1:0] a1_ff, a2_ff;
   wcr_pkg::vertex_type h2_ff;           // vertex as read, aligned with products
   wcr_pkg::vertex_type p_ff;            // start vertex of edge

   logic cordic_start;
   wcr_pkg::trig_type trig;
   logic wr_en;
   logic [wcr_pkg::VertW-1:0] wr_addr, rd_addr;
   wcr_pkg::vertex_type wr_data, rd_data, wb;
   wcr_pkg::coord_type ra, rb, ra_o, rb_o;

   assign cordic_start = (state_ff == S_TRIG_START);

   wcr_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start), .angle(ang_ff), .trig(trig)
   );

   // yaw uses (x,z): x' = c x - s z, z' = s x + c z
   // pitch uses (y,z): y' = c y + s z, z' = -s y + c z
   assign ra = phase_ff ? rd_data.y : rd_data.x;
   assign rb = rd_data.z;

   wcr_rotate u_rotate (
      .clock(clock), .cos_v(c_ff),
      .sin_a(phase_ff ? s_ff : -s_ff),
      .sin_b(phase_ff ? -s_ff : s_ff),
      .a(ra), .b(rb), .a_out(ra_o), .b_out(rb_o)
   );

   // Write-back: rotated pair merged into the vertex
   always_comb begin
      wb = h2_ff;
      wb.z = rb_o;
      if (phase_ff) wb.y = ra_o;
      else wb.x = ra_o;
   end

   assign wr_en   = (state_ff == S_CLEAR) || v2_ff;
   assign wr_addr = (state_ff == S_CLEAR) ? clr_ff : a2_ff;
   assign wr_data = (state_ff == S_CLEAR) ? wcr_pkg::corner(clr_ff) : wb;

   // Read address: rotation sweep, or edge endpoints
   always_comb begin
      case (state_ff)
         S_ROT:    rd_addr = rcnt_ff[wcr_pkg::VertW-1:0];
         S_EDGE_A: rd_addr = wcr_pkg::edge_vtx(edge_ff, 1'b0);
         S_EDGE_B: rd_addr = wcr_pkg::edge_vtx(edge_ff, 1'b1);
         default:  rd_addr = '0;
      endcase
   end

   wcr_vstore u_vstore (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic logic [6:0] scr_x(input wcr_pkg::coord_type v);
      logic [7:0] t;
      t = v[15] ? 8'(-((-{v[15], v}) >> 8)) : 8'(v >>> 8);
      scr_x = 7'(7'd64 + t[6:0]);
   endfunction
   function automatic logic [5:0] scr_y(input wcr_pkg::coord_type v);
      logic [16:0] n;
      logic [7:0] t;
      n = -{v[15], v};
      t = v[15] ? -(n[15:8]) : 8'(v >>> 8);
      scr_y = 6'(6'd32 + t[5:0]);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EDGE_OUT);

   // Sequencer
   always_ff @(posedge clock) begin
      a2_ff <= a1_ff;
      h2_ff <= rd_data;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
         v1_ff <= (state_ff == S_ROT) && (rcnt_ff != 4'(wcr_pkg::NumVert));
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == 3'(wcr_pkg::NumVert - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  pitch_ff <= req_pitch_angle;
                  edge_ff <= '0;
                  if (req_yaw_angle != 15'sd0) begin
                     ang_ff <= req_yaw_angle; phase_ff <= 1'b0;
                     state_ff <= S_TRIG_START;
                  end else if (req_pitch_angle != 15'sd0) begin
                     ang_ff <= req_pitch_angle; phase_ff <= 1'b1;
                     state_ff <= S_TRIG_START;
                  end else state_ff <= S_EDGE_A;
               end
            end
            S_TRIG_START: state_ff <= S_TRIG_WAIT;
            S_TRIG_WAIT: begin
               if (trig.done) begin
                  s_ff <= trig.sin_v; c_ff <= trig.cos_v;
                  rcnt_ff <= '0; wcnt_ff <= '0;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               if (rcnt_ff != 4'(wcr_pkg::NumVert)) begin
                  rcnt_ff <= rcnt_ff + 1'b1;
                  a1_ff <= rcnt_ff[wcr_pkg::VertW-1:0];
               end
               if (v2_ff) wcnt_ff <= wcnt_ff + 1'b1;
               if (v2_ff && wcnt_ff == 4'(wcr_pkg::NumVert - 1)) begin
                  if (!phase_ff && pitch_ff != 15'sd0) begin
                     ang_ff <= pitch_ff; phase_ff <= 1'b1;
                     state_ff <= S_TRIG_START;
                  end else state_ff <= S_EDGE_A;
               end
            end
            S_EDGE_A: state_ff <= S_EDGE_B;
            S_EDGE_B: begin
               p_ff <= rd_data;
               state_ff <= S_EDGE_C;
            end
            S_EDGE_C: begin
               rsp_x_start <= scr_x(p_ff.x);
               rsp_y_start <= scr_y(p_ff.y);
               rsp_x_end <= scr_x(rd_data.x);
               rsp_y_end <= scr_y(rd_data.y);
               rsp_last_segment <= (edge_ff == 4'(wcr_pkg::NumEdge - 1));
               state_ff <= S_EDGE_OUT;
            end
            S_EDGE_OUT: begin
               if (rsp_ready) begin
                  edge_ff <= edge_ff + 1'b1;
                  state_ff <= (edge_ff == 4'(wcr_pkg::NumEdge - 1)) ? S_IDLE : S_EDGE_A;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Memory written only while clearing or rotating
   a_wr_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_ROT))
      else $error("vertex write outside clear or rotation");
   // No new request while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and response overlap");
   // Last flag only on twelfth edge
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_segment) |-> (edge_ff == 4'(wcr_pkg::NumEdge - 1)))
      else $error("last flag on wrong edge");
endmodule
`default_nettype wire

>>> tb/wireframe_cube_rotator_tb.sv
// Testbench for wireframe_cube_rotator: drives yaw/pitch requests, predicts the
// endpoints of every cube edge per request and checks them in order. Depends on the RTL only.
`timescale 1ns / 1ps
module wireframe_cube_rotator_tb;

   localparam int NSTEPS    = 16;
   localparam int EDGES     = 12;
   localparam int LIMIT_CYC = 900000;

   typedef struct packed {
      logic [6:0] xs;
      logic [5:0] ys;
      logic [6:0] xe;
      logic [5:0] ye;
      logic       last;
   } seg_t;

   typedef struct {
      logic signed [14:0] yaw;
      logic signed [14:0] pitch;
      logic               has_exp;  // first edge typed in
      seg_t               exp0;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [14:0] req_yaw_angle = '0;
   logic signed [14:0] req_pitch_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [6:0] rsp_x_start, rsp_x_end;
   logic [5:0] rsp_y_start, rsp_y_end;
   logic rsp_last_segment;

   wireframe_cube_rotator u_dut (.*);

   // Predicted vertex positions, Q7.8
   longint cube_x[8], cube_y[8], cube_z[8];
   seg_t   edge_q[$];
   int     err_count = 0;
   int     edges_seen = 0;
   int     cyc = 0;
   int     send_idle = 31, recv_idle = 60;
   bit     hold_rsp = 1'b0;

   longint atan_tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
   int edge_a[EDGES] = '{0, 1, 2, 3, 4, 5, 6, 7, 7, 6, 5, 4};
   int edge_b[EDGES] = '{1, 2, 3, 0, 5, 6, 7, 4, 3, 2, 1, 0};

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void cube_reset();
      for (int i = 0; i < 8; i++) begin
         cube_x[i] = (i == 2 || i == 3 || i == 6 || i == 7) ? 3840 : -3840;
         cube_y[i] = (i == 1 || i == 2 || i == 5 || i == 6) ? 3840 : -3840;
         cube_z[i] = (i >= 4) ? 3840 : -3840;
      end
   endfunction

   // sin/cos in Q30 via folded CORDIC
   function automatic void sincos(input int ang, output longint sn, output longint cs);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(ang) * 262144;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 1686629713) begin
         z -= 64'sd3373259426; flip = 1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426; flip = 1;
      end
      for (int i = 0; i < NSTEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      cs = x;
      sn = y;
   endfunction

   function automatic longint round_sat(input longint p, input longint q);
      longint r;
      r = (p + q + 64'sd536870912) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic logic [6:0] to_screen(input longint v, input int base);
      longint t;
      t = (v < 0) ? -((-v) >>> 8) : (v >>> 8);
      return 7'(base + t);
   endfunction

   // Rotate the predicted cube and queue its edges
   function automatic void rotate_and_queue(input int yaw, input int pitch);
      longint s, c, a, b;
      seg_t e;
      if (yaw != 0) begin
         sincos(yaw, s, c);
         for (int i = 0; i < 8; i++) begin
            a = cube_x[i]; b = cube_z[i];
            cube_x[i] = round_sat(c * a, -(s * b));
            cube_z[i] = round_sat(s * a, c * b);
         end
      end
      if (pitch != 0) begin
         sincos(pitch, s, c);
         for (int i = 0; i < 8; i++) begin
            a = cube_y[i]; b = cube_z[i];
            cube_y[i] = round_sat(c * a, s * b);
            cube_z[i] = round_sat(-(s * a), c * b);
         end
      end
      for (int k = 0; k < EDGES; k++) begin
         e.xs = to_screen(cube_x[edge_a[k]], 64);
         e.ys = 6'(to_screen(cube_y[edge_a[k]], 32));
         e.xe = to_screen(cube_x[edge_b[k]], 64);
         e.ye = 6'(to_screen(cube_y[edge_b[k]], 32));
         e.last = (k == EDGES - 1);
         edge_q.push_back(e);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch edge %0d: %s got %0d want %0d", edges_seen, what, got, want);
      err_count++;
   endtask

   // Cycle counter and timeout
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > LIMIT_CYC) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result checking at the rising edge
   always @(posedge clock) begin
      seg_t w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (edge_q.size() == 0) begin
            report_mismatch("unexpected edge", rsp_x_start, 0);
         end else begin
            w = edge_q.pop_front();
            if (rsp_x_start !== w.xs) report_mismatch("x_start", rsp_x_start, w.xs);
            if (rsp_y_start !== w.ys) report_mismatch("y_start", rsp_y_start, w.ys);
            if (rsp_x_end !== w.xe) report_mismatch("x_end", rsp_x_end, w.xe);
            if (rsp_y_end !== w.ye) report_mismatch("y_end", rsp_y_end, w.ye);
            if (rsp_last_segment !== w.last)
               report_mismatch("last_segment", rsp_last_segment, w.last);
         end
         edges_seen++;
      end
   end

   // Receiver: random stalls, long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Drive one request, with random lead-in idling; valid stays up after acceptance
   // until the next idle cycle or the next request replaces the payload
   task automatic send_req(input logic signed [14:0] yaw, input logic signed [14:0] pitch);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_yaw_angle <= yaw;
      req_pitch_angle <= pitch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rotate_and_queue(yaw, pitch);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (edge_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [14:0] rand_angle();
      case ($urandom_range(5))
         0: return 15'sd0;
         1: return 15'($urandom_range(12868 * 2) - 12868);
         2: return 15'($urandom);
         default: return 15'($urandom_range(800) - 400);
      endcase
   endfunction

   dir_row_t dir_rows[$];
   int hold_len;

   initial begin
      cube_reset();
      // Directed rows: zero, extremes, quarter turns, folding, raw bit patterns
      dir_rows.push_back('{15'sd0, 15'sd0, 1'b1, '{7'd49, 6'd17, 7'd49, 6'd47, 1'b0}});
      dir_rows.push_back('{15'sd0, 15'sd0, 1'b0, '0});
      dir_rows.push_back('{15'sd6434, 15'sd0, 1'b0, '0});
      dir_rows.push_back('{-15'sd6434, 15'sd0, 1'b0, '0});
      dir_rows.push_back('{15'sd0, 15'sd6434, 1'b0, '0});
      dir_rows.push_back('{15'sd12868, 15'sd12868, 1'b0, '0});
      dir_rows.push_back('{-15'sd12868, -15'sd12868, 1'b0, '0});
      dir_rows.push_back('{15'sd16383, -15'sd16384, 1'b0, '0});
      dir_rows.push_back('{-15'sd16384, 15'sd16383, 1'b0, '0});
      dir_rows.push_back('{15'sd6435, -15'sd6435, 1'b0, '0});
      dir_rows.push_back('{15'sd1, -15'sd1, 1'b0, '0});
      dir_rows.push_back('{15'sd9000, 15'sd3000, 1'b0, '0});
      dir_rows.push_back('{15'sh2AAA, 15'sh5555, 1'b0, '0});
      dir_rows.push_back('{15'sh5555, 15'sh2AAA, 1'b0, '0});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, first row checks the reset cube directly
      foreach (dir_rows[i]) begin
         if (dir_rows[i].has_exp) begin
            seg_t p;
            send_req(dir_rows[i].yaw, dir_rows[i].pitch);
            p = edge_q[0];
            if (p !== dir_rows[i].exp0)
               report_mismatch("reset cube first edge", p, dir_rows[i].exp0);
         end else begin
            send_req(dir_rows[i].yaw, dir_rows[i].pitch);
         end
      end

      // Random part in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
         recv_idle = (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
         for (int n = 0; n < 100; n++) begin
            if (ph == 0 && n == 20) begin
               // long receiver hold-off while requests keep coming
               hold_rsp = 1'b1;
               fork
                  begin
                     hold_len = 0;
                     while (hold_len < 400) begin
                        @(posedge clock);
                        hold_len++;
                     end
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            if (n == 50) drain();
            send_req(rand_angle(), rand_angle());
         end
      end

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d edges over %0d directed and 300 random requests",
               edges_seen, dir_rows.size());
      if (err_count == 0 && edge_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
